[rtl/rk4_pkg.sv]
package rk4_pkg;

   // State number format and the fixed formats of the register and result fields.
   localparam int STATE_WIDTH     = 32;
   localparam int STATE_FRAC_BITS = 28;
   localparam int IO_W            = 32;
   localparam int IO_FRAC         = 28;
   localparam int CFG_W           = 32;
   localparam int COUNT_W         = 24;
   localparam int OMEGA_FRAC      = 24;
   localparam int DT_FRAC         = 32;
   localparam int CSR_INDEX_W     = 3;

   localparam int UP_SHIFT   = (STATE_FRAC_BITS >= IO_FRAC) ? STATE_FRAC_BITS - IO_FRAC : 0;
   localparam int DOWN_SHIFT = (STATE_FRAC_BITS < IO_FRAC) ? IO_FRAC - STATE_FRAC_BITS : 0;

   // Weighted slope sums carry three more bits than the state.
   localparam int SUM_W      = STATE_WIDTH + 3;
   localparam int QUOT_W     = STATE_WIDTH + 1;
   localparam int DIV_DIGITS = (SUM_W + 3) / 4;
   localparam int DIV_W      = DIV_DIGITS * 4;
   localparam int DIV_CNT_W  = $clog2(DIV_DIGITS + 1);
   localparam int CONV_W     = IO_W + STATE_WIDTH + 2;

   // Multiplier datapath widths.
   localparam int PROD_W = STATE_WIDTH + CFG_W;
   localparam int RND_W  = PROD_W + 1;

   // Reciprocal of six scaled by 2^8, exact for dividends below 96.
   localparam logic [5:0] RECIP_SIX = 6'd43;
   localparam logic [6:0] SIX       = 7'd6;

   localparam logic [CFG_W-1:0]   OMEGA_RESET         = 32'd16777216;
   localparam logic [CFG_W-1:0]   STEP_SIZE_RESET     = 32'd42949673;
   localparam logic [COUNT_W-1:0] TOTAL_STEPS_RESET   = 24'd1000;
   localparam logic [CFG_W-1:0]   INIT_POSITION_RESET = 32'd265106866;
   localparam logic [CFG_W-1:0]   INIT_VELOCITY_RESET = 32'd0;

   typedef logic signed [STATE_WIDTH-1:0] state_type;
   typedef logic signed [SUM_W-1:0]       sum_type;
   typedef logic signed [QUOT_W-1:0]      quot_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OMEGA         = 3'd0,
      CSR_STEP_SIZE     = 3'd1,
      CSR_TOTAL_STEPS   = 3'd2,
      CSR_INIT_POSITION = 3'd3,
      CSR_INIT_VELOCITY = 3'd4
   } csr_reg_type;

   typedef enum logic {
      SHIFT_OMEGA,
      SHIFT_DT
   } shift_sel_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ISSUE,
      SEQ_WAIT,
      SEQ_AUX,
      SEQ_DIV_START,
      SEQ_DIV_WAIT,
      SEQ_FINAL,
      SEQ_OUT
   } seq_state_type;

   typedef struct packed {
      logic             start;
      state_type        a;
      logic [CFG_W-1:0] b;
      shift_sel_type    shift;
      logic             neg;
   } mul_req_type;

   typedef struct packed {
      logic      done;
      state_type value;
      logic      sat;
   } mul_rsp_type;

   typedef struct packed {
      logic     done;
      quot_type quot;
   } div_rsp_type;

   typedef struct packed {
      state_type value;
      logic      sat;
   } sat_val_type;

   typedef struct packed {
      logic [IO_W-1:0] value;
      logic            sat;
   } io_val_type;

   localparam logic signed [STATE_WIDTH+1:0] SUM_SMAX = {3'b000, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH+1:0] SUM_SMIN = {3'b111, {(STATE_WIDTH-1){1'b0}}};
   localparam logic signed [CONV_W-1:0] CONV_SMAX =
      {{(CONV_W-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [CONV_W-1:0] CONV_SMIN =
      {{(CONV_W-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
   localparam logic signed [CONV_W-1:0] CONV_IO_MAX =
      {{(CONV_W-IO_W+1){1'b0}}, {(IO_W-1){1'b1}}};
   localparam logic signed [CONV_W-1:0] CONV_IO_MIN =
      {{(CONV_W-IO_W+1){1'b1}}, {(IO_W-1){1'b0}}};

   function automatic sat_val_type clamp_sum(logic signed [STATE_WIDTH+1:0] s);
      sat_val_type r;
      if (s > SUM_SMAX) begin
         r.value = SUM_SMAX[STATE_WIDTH-1:0];
         r.sat   = 1'b1;
      end else if (s < SUM_SMIN) begin
         r.value = SUM_SMIN[STATE_WIDTH-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = s[STATE_WIDTH-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

   function automatic sat_val_type sat_add(state_type a, logic signed [STATE_WIDTH:0] b);
      logic signed [STATE_WIDTH+1:0] s;
      s = (STATE_WIDTH+2)'(a) + (STATE_WIDTH+2)'(b);
      return clamp_sum(s);
   endfunction

   function automatic sat_val_type to_state(logic [IO_W-1:0] reg_value);
      logic signed [CONV_W-1:0] w;
      sat_val_type              r;
      w = CONV_W'(signed'(reg_value));
      w = w <<< UP_SHIFT;
      w = w >>> DOWN_SHIFT;
      if (w > CONV_SMAX) begin
         r.value = CONV_SMAX[STATE_WIDTH-1:0];
         r.sat   = 1'b1;
      end else if (w < CONV_SMIN) begin
         r.value = CONV_SMIN[STATE_WIDTH-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = w[STATE_WIDTH-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

   function automatic io_val_type to_io(state_type v);
      logic signed [CONV_W-1:0] w;
      io_val_type               r;
      w = CONV_W'(v);
      w = w >>> UP_SHIFT;
      w = w <<< DOWN_SHIFT;
      if (w > CONV_IO_MAX) begin
         r.value = CONV_IO_MAX[IO_W-1:0];
         r.sat   = 1'b1;
      end else if (w < CONV_IO_MIN) begin
         r.value = CONV_IO_MIN[IO_W-1:0];
         r.sat   = 1'b1;
      end else begin
         r.value = w[IO_W-1:0];
         r.sat   = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/rk4_if.sv]
interface rk4_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface rk4_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] position;
   logic [31:0] velocity;
   logic [23:0] step_index;
   logic        last_step;
   logic        idle_tick;
   logic        saturated;

   modport source (output valid, output position, output velocity, output step_index,
                   output last_step, output idle_tick, output saturated, input ready);
   modport sink (input valid, input position, input velocity, input step_index,
                 input last_step, input idle_tick, input saturated, output ready);
endinterface

interface rk4_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/rk4_harmonic_oscillator_step_core.sv]
// A tick that takes a step holds the block through sixteen passes through the shared
// three-stage multiplier, three stage-point updates, and a nine-digit divide by six run
// on position and velocity side by side.
// A tick after the run has ended goes from acceptance straight to the output state.
// One tick is in flight at a time; a finished beat may wait in the output register.
// Synchronous active-high reset loads the register defaults and the initial state.
module rk4_harmonic_oscillator_step_core
   import rk4_pkg::*;
(
   input logic         clock,
   input logic         reset,
   rk4_req_if.sink     req_bus,
   rk4_rsp_if.source   rsp_bus,
   rk4_csr_if.sink     csr_bus
);

   logic [CFG_W-1:0]   omega_ff;
   logic [CFG_W-1:0]   step_size_ff;
   logic [COUNT_W-1:0] total_ff;
   logic [CFG_W-1:0]   init_pos_ff;
   logic [CFG_W-1:0]   init_vel_ff;

   seq_state_type      state_ff, state_in;
   logic [1:0]         slope_ff, slope_in;
   logic [1:0]         sub_ff, sub_in;
   state_type          x_ff, x_in, v_ff, v_in;
   state_type          xa_ff, xa_in, va_ff, va_in;
   state_type          kp_ff, kp_in, kv_ff, kv_in, t_ff, t_in;
   sum_type            sp_ff, sp_in, sv_ff, sv_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic               last_ff, last_in, idle_ff, idle_in, sat_ff, sat_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [IO_W-1:0]    rsp_pos_ff, rsp_pos_in, rsp_vel_ff, rsp_vel_in;
   logic [COUNT_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in, rsp_idle_ff, rsp_idle_in;
   logic               rsp_sat_ff, rsp_sat_in;

   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;
   logic               div_start;
   div_rsp_type        div_p_rsp, div_v_rsp;

   sat_val_type        ld_x, ld_v, aux_x, aux_v, fin_x, fin_v;
   io_val_type         io_x, io_v;
   logic [COUNT_W-1:0] eff_cnt, cnt_next;
   logic               heavy;
   sum_type            w_res;
   logic signed [STATE_WIDTH:0] step_kp, step_kv;

   rk4_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   rk4_div6 u_div_pos (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sp_ff),
      .rsp      (div_p_rsp)
   );

   rk4_div6 u_div_vel (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sv_ff),
      .rsp      (div_v_rsp)
   );

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == SEQ_IDLE);

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.position   = rsp_pos_ff;
   assign rsp_bus.velocity   = rsp_vel_ff;
   assign rsp_bus.step_index = rsp_idx_ff;
   assign rsp_bus.last_step  = rsp_last_ff;
   assign rsp_bus.idle_tick  = rsp_idle_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

   // Operand selection for the four products of one slope pair.
   always_comb begin
      mul_req.start = (state_ff == SEQ_ISSUE);
      unique case (sub_ff)
         2'd0: begin
            mul_req.a     = va_ff;
            mul_req.b     = step_size_ff;
            mul_req.shift = SHIFT_DT;
            mul_req.neg   = 1'b0;
         end
         2'd1: begin
            mul_req.a     = xa_ff;
            mul_req.b     = omega_ff;
            mul_req.shift = SHIFT_OMEGA;
            mul_req.neg   = 1'b0;
         end
         2'd2: begin
            mul_req.a     = t_ff;
            mul_req.b     = omega_ff;
            mul_req.shift = SHIFT_OMEGA;
            mul_req.neg   = 1'b0;
         end
         default: begin
            mul_req.a     = t_ff;
            mul_req.b     = step_size_ff;
            mul_req.shift = SHIFT_DT;
            mul_req.neg   = 1'b1;
         end
      endcase
   end

   always_comb begin
      ld_x    = to_state(init_pos_ff);
      ld_v    = to_state(init_vel_ff);
      eff_cnt = req_bus.restart ? '0 : cnt_ff;
      cnt_next = cnt_ff + COUNT_W'(1);

      // The middle two slopes count twice in the weighted sum.
      heavy = (slope_ff == 2'd1) || (slope_ff == 2'd2);
      w_res = heavy ? (SUM_W'(mul_rsp.value) <<< 1) : SUM_W'(mul_rsp.value);

      // The first two stage points use half a slope, the last one a full slope.
      step_kp = (slope_ff == 2'd2) ? (STATE_WIDTH+1)'(kp_ff) : (STATE_WIDTH+1)'(kp_ff >>> 1);
      step_kv = (slope_ff == 2'd2) ? (STATE_WIDTH+1)'(kv_ff) : (STATE_WIDTH+1)'(kv_ff >>> 1);
      aux_x   = sat_add(x_ff, step_kp);
      aux_v   = sat_add(v_ff, step_kv);
      fin_x   = sat_add(x_ff, div_p_rsp.quot);
      fin_v   = sat_add(v_ff, div_v_rsp.quot);
      io_x    = to_io(x_ff);
      io_v    = to_io(v_ff);
   end

   always_comb begin
      state_in = state_ff;
      slope_in = slope_ff;
      sub_in   = sub_ff;
      x_in     = x_ff;
      v_in     = v_ff;
      xa_in    = xa_ff;
      va_in    = va_ff;
      kp_in    = kp_ff;
      kv_in    = kv_ff;
      t_in     = t_ff;
      sp_in    = sp_ff;
      sv_in    = sv_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      idle_in  = idle_ff;
      sat_in   = sat_ff;
      div_start = 1'b0;

      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_bus.valid) begin
               sat_in = 1'b0;
               xa_in  = x_ff;
               va_in  = v_ff;
               if (req_bus.restart) begin
                  x_in   = ld_x.value;
                  v_in   = ld_v.value;
                  xa_in  = ld_x.value;
                  va_in  = ld_v.value;
                  sat_in = ld_x.sat | ld_v.sat;
               end
               cnt_in   = eff_cnt;
               idx_in   = eff_cnt;
               last_in  = 1'b0;
               sp_in    = '0;
               sv_in    = '0;
               slope_in = 2'd0;
               sub_in   = 2'd0;
               if (eff_cnt >= total_ff) begin
                  idle_in  = 1'b1;
                  state_in = SEQ_OUT;
               end else begin
                  idle_in  = 1'b0;
                  state_in = SEQ_ISSUE;
               end
            end
         end
         SEQ_ISSUE: begin
            state_in = SEQ_WAIT;
         end
         SEQ_WAIT: begin
            if (mul_rsp.done) begin
               sat_in = sat_ff | mul_rsp.sat;
               unique case (sub_ff)
                  2'd0: begin
                     kp_in = mul_rsp.value;
                     sp_in = sp_ff + w_res;
                  end
                  2'd1, 2'd2: begin
                     t_in = mul_rsp.value;
                  end
                  default: begin
                     kv_in = mul_rsp.value;
                     sv_in = sv_ff + w_res;
                  end
               endcase
               if (sub_ff != 2'd3) begin
                  sub_in   = sub_ff + 2'd1;
                  state_in = SEQ_ISSUE;
               end else begin
                  sub_in   = 2'd0;
                  state_in = (slope_ff == 2'd3) ? SEQ_DIV_START : SEQ_AUX;
               end
            end
         end
         SEQ_AUX: begin
            xa_in    = aux_x.value;
            va_in    = aux_v.value;
            sat_in   = sat_ff | aux_x.sat | aux_v.sat;
            slope_in = slope_ff + 2'd1;
            state_in = SEQ_ISSUE;
         end
         SEQ_DIV_START: begin
            div_start = 1'b1;
            state_in  = SEQ_DIV_WAIT;
         end
         SEQ_DIV_WAIT: begin
            if (div_p_rsp.done) begin
               state_in = SEQ_FINAL;
            end
         end
         SEQ_FINAL: begin
            x_in     = fin_x.value;
            v_in     = fin_v.value;
            sat_in   = sat_ff | fin_x.sat | fin_v.sat;
            cnt_in   = cnt_next;
            last_in  = (cnt_next == total_ff);
            state_in = SEQ_OUT;
         end
         default: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = io_x.value;
               rsp_vel_in   = io_v.value;
               rsp_idx_in   = idx_ff;
               rsp_last_in  = last_ff;
               rsp_idle_in  = idle_ff;
               rsp_sat_in   = sat_ff | io_x.sat | io_v.sat;
               state_in     = SEQ_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         omega_ff     <= OMEGA_RESET;
         step_size_ff <= STEP_SIZE_RESET;
         total_ff     <= TOTAL_STEPS_RESET;
         init_pos_ff  <= INIT_POSITION_RESET;
         init_vel_ff  <= INIT_VELOCITY_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_OMEGA:         omega_ff     <= csr_bus.data;
            CSR_STEP_SIZE:     step_size_ff <= csr_bus.data;
            CSR_TOTAL_STEPS:   total_ff     <= csr_bus.data[COUNT_W-1:0];
            CSR_INIT_POSITION: init_pos_ff  <= csr_bus.data;
            CSR_INIT_VELOCITY: init_vel_ff  <= csr_bus.data;
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         slope_ff     <= 2'd0;
         sub_ff       <= 2'd0;
         x_ff         <= to_state(INIT_POSITION_RESET).value;
         v_ff         <= to_state(INIT_VELOCITY_RESET).value;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slope_ff     <= slope_in;
         sub_ff       <= sub_in;
         x_ff         <= x_in;
         v_ff         <= v_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff       <= xa_in;
      va_ff       <= va_in;
      kp_ff       <= kp_in;
      kv_ff       <= kv_in;
      t_ff        <= t_in;
      sp_ff       <= sp_in;
      sv_ff       <= sv_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      idle_ff     <= idle_in;
      sat_ff      <= sat_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_idle_ff <= rsp_idle_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

endmodule

[rtl/rk4_mul.sv]
module rk4_mul
   import rk4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   // Stage A: magnitude and result sign.
   logic                   a_valid_ff, a_valid_in;
   logic [STATE_WIDTH-1:0] mag_ff, mag_in;
   logic [CFG_W-1:0]       b_ff;
   shift_sel_type          a_shift_ff;
   logic                   a_negr_ff, a_negr_in;

   // Stage B: full product.
   logic                   b_valid_ff;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   shift_sel_type          b_shift_ff;
   logic                   b_negr_ff;

   // Stage C: rounded, clamped and signed result.
   logic                   c_valid_ff;
   state_type              value_ff, value_in;
   logic                   sat_ff, sat_in;

   logic [RND_W-1:0]       rnd;
   logic [RND_W-1:0]       shifted;
   logic [RND_W-1:0]       lim;
   logic [RND_W-1:0]       mag_r;
   state_type              mag_s;

   always_comb begin
      a_valid_in = req.start;
      a_negr_in  = req.a[STATE_WIDTH-1] ^ req.neg;
      mag_in     = req.a[STATE_WIDTH-1] ? STATE_WIDTH'(-req.a) : STATE_WIDTH'(req.a);
      prod_in    = PROD_W'(mag_ff) * PROD_W'(b_ff);
   end

   always_comb begin
      if (b_shift_ff == SHIFT_OMEGA) begin
         rnd     = RND_W'(prod_ff) + (RND_W'(1) << (OMEGA_FRAC - 1));
         shifted = rnd >> OMEGA_FRAC;
      end else begin
         rnd     = RND_W'(prod_ff) + (RND_W'(1) << (DT_FRAC - 1));
         shifted = rnd >> DT_FRAC;
      end
      // A negative result may reach one past the positive limit.
      lim    = b_negr_ff ? (RND_W'(1) << (STATE_WIDTH - 1))
                         : ((RND_W'(1) << (STATE_WIDTH - 1)) - RND_W'(1));
      sat_in = shifted > lim;
      mag_r  = sat_in ? lim : shifted;
      mag_s  = mag_r[STATE_WIDTH-1:0];
      value_in = b_negr_ff ? -mag_s : mag_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      b_ff       <= req.b;
      a_shift_ff <= req.shift;
      a_negr_ff  <= a_negr_in;
      prod_ff    <= prod_in;
      b_shift_ff <= a_shift_ff;
      b_negr_ff  <= a_negr_ff;
      value_ff   <= value_in;
      sat_ff     <= sat_in;
   end

   assign rsp.done  = c_valid_ff;
   assign rsp.value = value_ff;
   assign rsp.sat   = sat_ff;

endmodule

[rtl/rk4_div6.sv]
module rk4_div6
   import rk4_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  sum_type     dividend,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     mag_ff, mag_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [2:0]           rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   quot_type             res_ff, res_in;

   sum_type              start_mag;
   logic [6:0]           partial;
   logic [11:0]          scaled;
   logic [3:0]           digit;
   logic [6:0]           rem_wide;
   logic [DIV_W-1:0]     quot_next;
   quot_type             quot_final;

   always_comb begin
      // Floor toward minus infinity: a negative sum divides its magnitude plus five.
      start_mag = dividend[SUM_W-1] ? (-dividend + SUM_W'(5)) : dividend;

      partial   = {rem_ff, mag_ff[DIV_W-1 -: 4]};
      scaled    = 12'(partial) * 12'(RECIP_SIX);
      digit     = scaled[11:8];
      rem_wide  = partial - 7'(digit) * SIX;
      quot_next = {quot_ff[DIV_W-5:0], digit};
      quot_final = quot_next[QUOT_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_DIGITS);
         mag_in  = DIV_W'($unsigned(start_mag));
         quot_in = '0;
         rem_in  = '0;
         neg_in  = dividend[SUM_W-1];
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         mag_in  = mag_ff << 4;
         quot_in = quot_next;
         rem_in  = rem_wide[2:0];
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = neg_ff ? -quot_final : quot_final;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = res_ff;

endmodule

[rtl/rk4_checker.sv]
module rk4_checker
   import rk4_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [IO_W-1:0]    rsp_position,
   input logic [IO_W-1:0]    rsp_velocity,
   input logic [COUNT_W-1:0] rsp_step_index,
   input logic               rsp_last_step,
   input logic               rsp_idle_tick
);

   // Only one tick is worked on at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a tick is still in progress");

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position)
         && $stable(rsp_velocity) && $stable(rsp_step_index)))
      else $error("stalled result beat changed");

   // A tick that takes no step cannot end the run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_idle_tick && rsp_last_step))
      else $error("idle tick flagged as the last step");

endmodule

bind rk4_harmonic_oscillator_step_core rk4_checker u_rk4_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_position   (rsp_bus.position),
   .rsp_velocity   (rsp_bus.velocity),
   .rsp_step_index (rsp_bus.step_index),
   .rsp_last_step  (rsp_bus.last_step),
   .rsp_idle_tick  (rsp_bus.idle_tick)
);
